/* rtl/onenc_pkg.sv */
// ----------------------------------------------------------------------------
// onenc_pkg
// Shared types and constants for the octahedral normal encoder.
// ----------------------------------------------------------------------------
package onenc_pkg;

	localparam int CODE_BITS  = 8;
	localparam int DIV_STAGES = CODE_BITS;
	localparam int BYTE_MAX   = 255;

	typedef logic [CODE_BITS-1:0] code_t;

	localparam code_t ZERO_CODE = code_t'(127);

endpackage

/* rtl/onenc_if.sv */
// ----------------------------------------------------------------------------
// onenc_if
// Valid/ready channels for normal vector beats and code beats.
// ----------------------------------------------------------------------------
interface onenc_in_if #(parameter int COMPONENT_BITS = 16) ();

	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] comp_x;
	logic signed [COMPONENT_BITS-1:0] comp_y;
	logic signed [COMPONENT_BITS-1:0] comp_z;

	modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
	modport sink (input valid, input comp_x, input comp_y, input comp_z, output ready);

endinterface

interface onenc_out_if import onenc_pkg::*; ();

	logic  valid;
	logic  ready;
	code_t code_x;
	code_t code_y;
	logic  zero_vector;

	modport source (output valid, output code_x, output code_y, output zero_vector, input ready);
	modport sink (input valid, input code_x, input code_y, input zero_vector, output ready);

endinterface

/* rtl/onenc_div.sv */
// ----------------------------------------------------------------------------
// onenc_div
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
// ----------------------------------------------------------------------------
module onenc_div import onenc_pkg::*; #(
	parameter int NUM_BITS = 26,
	parameter int DEN_BITS = 18
) (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [NUM_BITS-1:0]   num,
	input  logic [DEN_BITS-1:0]   den,
	output code_t                 quo
);

	logic [NUM_BITS-1:0] rem_s [DIV_STAGES-1];
	logic [DEN_BITS-1:0] den_s [DIV_STAGES-1];
	code_t               quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
		localparam int SH = DIV_STAGES - 1 - k;

		logic [NUM_BITS-1:0] rem_in;
		logic [DEN_BITS-1:0] den_in;
		code_t               quo_in;
		code_t               quo_nx;
		logic [NUM_BITS:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {1'b0, rem_in} - ((NUM_BITS+1)'(den_in) << SH);

		always_comb begin
			quo_nx     = quo_in;
			quo_nx[SH] = !trial[NUM_BITS];
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k] <= quo_nx;
			end
		end

		if (k < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= trial[NUM_BITS] ? rem_in : trial[NUM_BITS-1:0];
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

/* rtl/oct_normal_encode_top.sv */
// ----------------------------------------------------------------------------
// oct_normal_encode_top
// Octahedral encoding of a normal vector into two 8-bit codes.
// ----------------------------------------------------------------------------
// pipeline: 4 front stages (s1 to s4) and 8 divider stages between input beat and result beat
// throughput: one beat per cycle while code.ready lets the pipe advance, set by the one-bit-per-stage divider lanes
// each stage stalls only when full and blocked, so bubbles are absorbed under backpressure
// reset clears all stage valid bits and biased_byte_mode
// ----------------------------------------------------------------------------
module oct_normal_encode_top import onenc_pkg::*; #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	onenc_in_if.sink       vec,
	onenc_out_if.source    code
);

	localparam int W      = COMPONENT_BITS;
	localparam int LW     = W + 1;
	localparam int DW     = W + 2;
	localparam int NW     = DW + CODE_BITS;
	localparam int NFRONT = 4;
	localparam int NSTG   = NFRONT + DIV_STAGES;

	function automatic logic [W:0] dec_mag(input logic [W-1:0] raw, input logic bm);
		logic [8:0]   bv;
		logic [W-1:0] v;
		bv = {raw[7:0], 1'b0} - 9'(BYTE_MAX);
		if (bm) begin
			v = W'($signed(bv));
		end else begin
			v = raw;
		end
		return {v[W-1], v[W-1] ? (~v + 1'b1) : v};
	endfunction

	logic            biased_byte_mode_q;
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] en;
	logic [NSTG-1:0] vld_in;

	logic [W:0]      dx, dy, dz;
	logic [W-1:0]    mag_x_s1, mag_y_s1, mag_z_s1;
	logic            neg_x_s1, neg_y_s1, neg_z_s1;
	logic [LW-1:0]   len_s2;
	logic [W-1:0]    mag_x_s2, mag_y_s2;
	logic            neg_x_s2, neg_y_s2, neg_z_s2;
	logic [DW-1:0]   len_w, len2_w, ax_w, ay_w, np_nx, nq_nx;
	logic [DW-1:0]   np_s3, nq_s3, den_s3;
	logic            zero_s3;
	logic [NW-1:0]   num_p_s4, num_q_s4;
	logic [DW-1:0]   den_s4;
	logic            zero_s4;
	logic            zero_d_s [DIV_STAGES];
	code_t           quo_p, quo_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biased_byte_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			biased_byte_mode_q <= cfg_wr_data;
		end
	end

	// per-stage advance, from the output back
	always_comb begin
		logic nxt;
		nxt = code.ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || nxt;
			nxt   = en[k];
		end
	end

	assign vld_in    = {vld_s[NSTG-2:0], vec.valid};
	assign vec.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	// s1: decode and magnitude
	assign dx = dec_mag(vec.comp_x, biased_byte_mode_q);
	assign dy = dec_mag(vec.comp_y, biased_byte_mode_q);
	assign dz = dec_mag(vec.comp_z, biased_byte_mode_q);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			{neg_x_s1, mag_x_s1} <= dx;
			{neg_y_s1, mag_y_s1} <= dy;
			{neg_z_s1, mag_z_s1} <= dz;
		end
	end

	// s2: l1 length
	always_ff @(posedge clk) begin
		if (en[1]) begin
			len_s2   <= LW'(mag_x_s1) + LW'(mag_y_s1) + LW'(mag_z_s1);
			mag_x_s2 <= mag_x_s1;
			mag_y_s2 <= mag_y_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			neg_z_s2 <= neg_z_s1;
		end
	end

	// s3: p + L and q + L, folded for the lower hemisphere
	assign len_w  = DW'(len_s2);
	assign len2_w = {len_s2, 1'b0};
	assign ax_w   = DW'(mag_x_s2);
	assign ay_w   = DW'(mag_y_s2);

	always_comb begin
		case ({neg_z_s2, neg_x_s2})
			2'b00:   np_nx = len_w + ax_w;
			2'b01:   np_nx = len_w - ax_w;
			2'b10:   np_nx = len2_w - ay_w;
			default: np_nx = ay_w;
		endcase
		case ({neg_z_s2, neg_y_s2})
			2'b00:   nq_nx = len_w + ay_w;
			2'b01:   nq_nx = len_w - ay_w;
			2'b10:   nq_nx = len2_w - ax_w;
			default: nq_nx = ax_w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			np_s3   <= np_nx;
			nq_s3   <= nq_nx;
			den_s3  <= len2_w;
			zero_s3 <= (len_s2 == '0);
		end
	end

	// s4: scale by 255
	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_p_s4 <= (NW'(np_s3) << CODE_BITS) - NW'(np_s3);
			num_q_s4 <= (NW'(nq_s3) << CODE_BITS) - NW'(nq_s3);
			den_s4   <= den_s3;
			zero_s4  <= zero_s3;
		end
	end

	onenc_div #(
		.NUM_BITS(NW),
		.DEN_BITS(DW)
	) u_div_p (
		.clk (clk),
		.en  (en[NSTG-1:NFRONT]),
		.num (num_p_s4),
		.den (den_s4),
		.quo (quo_p)
	);

	onenc_div #(
		.NUM_BITS(NW),
		.DEN_BITS(DW)
	) u_div_q (
		.clk (clk),
		.en  (en[NSTG-1:NFRONT]),
		.num (num_q_s4),
		.den (den_s4),
		.quo (quo_q)
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_zero
		always_ff @(posedge clk) begin
			if (en[NFRONT+k]) begin
				zero_d_s[k] <= (k == 0) ? zero_s4 : zero_d_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign code.valid       = vld_s[NSTG-1];
	assign code.zero_vector = zero_d_s[DIV_STAGES-1];
	assign code.code_x      = zero_d_s[DIV_STAGES-1] ? ZERO_CODE : quo_p;
	assign code.code_y      = zero_d_s[DIV_STAGES-1] ? ZERO_CODE : quo_q;

endmodule

/* rtl/onenc_chk.sv */
// ----------------------------------------------------------------------------
// onenc_chk
// Port-level checks for the octahedral normal encoder, bound to the top.
// ----------------------------------------------------------------------------
module onenc_chk import onenc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input code_t code_x,
	input code_t code_y,
	input logic  zero_vector
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_x) && $stable(code_y)
			&& $stable(zero_vector))
		else $error("result beat changed while stalled");

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> code_x == ZERO_CODE && code_y == ZERO_CODE)
		else $error("zero vector without neutral codes");

	// input only blocks when the pipe is full behind a stalled result
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked while output moves");

	// valid bits are cleared by the asynchronous reset, so no result beat follows a sampled reset
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result beat during reset");

	// result valid stays known once beats go in
	a_acc_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$isunknown(out_valid))
		else $error("result valid unknown after input beat");

endmodule

bind oct_normal_encode_top onenc_chk u_onenc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (vec.valid),
	.in_ready    (vec.ready),
	.out_valid   (code.valid),
	.out_ready   (code.ready),
	.code_x      (code.code_x),
	.code_y      (code.code_y),
	.zero_vector (code.zero_vector)
);
